@@ rtl/sme_pkg.sv @@
// Package for the integer stack-machine executor: opcodes, status codes,
// payload field widths and shared controller/datapath command types.
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;
   localparam int unsigned WordWidth = 64;
   localparam int unsigned OpWidth   = 5;
   localparam int unsigned SelWidth  = 4;
   localparam int unsigned StatWidth = 3;

   typedef enum logic [OpWidth-1:0] {
      OP_PUSH_IMM = 5'd0, OP_PUSH_ZERO = 5'd1, OP_PUSH_ONE = 5'd2, OP_PUSH_M1 = 5'd3,
      OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_MOD = 5'd8,
      OP_OR = 5'd9, OP_AND = 5'd10, OP_XOR = 5'd11, OP_NEG = 5'd12, OP_PRINT = 5'd13,
      OP_POP = 5'd14, OP_LOAD_LOC = 5'd15, OP_STORE_LOC = 5'd16, OP_LOAD_CTX = 5'd17,
      OP_STORE_CTX = 5'd18, OP_SET_CTX = 5'd19
   } op_type;

   localparam logic [StatWidth-1:0] ST_OK        = 3'd0;
   localparam logic [StatWidth-1:0] ST_UNDER     = 3'd1;
   localparam logic [StatWidth-1:0] ST_OVER      = 3'd2;
   localparam logic [StatWidth-1:0] ST_DIVZERO   = 3'd3;
   localparam logic [StatWidth-1:0] ST_UNWRITTEN = 3'd4;
   localparam logic [StatWidth-1:0] ST_BADOP     = 3'd5;

   // Datapath actions issued by the controller.
   typedef enum logic [2:0] {
      ACT_NONE, ACT_READ, ACT_PUSH, ACT_LOAD, ACT_ALU, ACT_DIV_START,
      ACT_DIV_DONE, ACT_STORE
   } act_type;

   typedef struct packed {
      act_type               act;
      logic [OpWidth-1:0]    op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic b_zero;
      logic var_valid;
   } sts_type;
endpackage
`default_nettype wire

@@ rtl/sme_if.sv @@
// Valid/ready channel interface carrying one item payload.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface sme_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/sme_divider.sv @@
// Radix-2 signed divider, one quotient bit per cycle, truncating quotient.
// Depends on sme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sme_divider import sme_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WordWidth-1:0] dividend,
   input  wire logic [WordWidth-1:0] divisor,
   output logic                      busy,
   output logic [WordWidth-1:0]      quotient,
   output logic [WordWidth-1:0]      remainder
);
   localparam int unsigned CntWidth = $clog2(WordWidth + 1);
   logic [WordWidth-1:0] q_ff, q_in, d_ff, d_in;
   logic [WordWidth:0]   r_ff, r_in, trial;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [WordWidth-1:0] mag_a, mag_b;

   assign mag_a = dividend[WordWidth-1] ? -dividend : dividend;
   assign mag_b = divisor[WordWidth-1] ? -divisor : divisor;
   assign trial = {r_ff[WordWidth-1:0], q_ff[WordWidth-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      if (start) begin
         q_in = mag_a; r_in = '0; d_in = mag_b;
         cnt_in = CntWidth'(WordWidth);
         qneg_in = dividend[WordWidth-1] ^ divisor[WordWidth-1];
         rneg_in = dividend[WordWidth-1];
      end else if (cnt_ff != '0) begin
         if (trial[WordWidth]) begin
            r_in = {r_ff[WordWidth-1:0], q_ff[WordWidth-1]};
            q_in = {q_ff[WordWidth-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[WordWidth-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = qneg_ff ? -q_ff : q_ff;
   assign remainder = rneg_ff ? -r_ff[WordWidth-1:0] : r_ff[WordWidth-1:0];
endmodule
`default_nettype wire

@@ rtl/sme_datapath.sv @@
// Datapath: operand stack memory, variable store memory, ALU, divider, multiplier.
// Depends on sme_pkg and sme_divider.
`timescale 1ns / 1ps
`default_nettype none
module sme_datapath import sme_pkg::*; #(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned NUM_CONTEXTS = 16,
   parameter int unsigned VARS_PER_CONTEXT = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  cmd_type                   cmd,
   input  wire logic [WordWidth-1:0] push_value,
   input  wire logic [$clog2(STACK_DEPTH+1)-1:0] count,
   input  wire logic [$clog2(NUM_CONTEXTS*VARS_PER_CONTEXT)-1:0] var_idx,
   output sts_type                   sts,
   output logic [WordWidth-1:0]      top_value
);
   localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);
   localparam int unsigned StackAw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned StoreSize = NUM_CONTEXTS * VARS_PER_CONTEXT;
   localparam int unsigned StoreAw = (StoreSize > 1) ? $clog2(StoreSize) : 1;
   localparam int unsigned HalfWidth = WordWidth / 2;

   logic [WordWidth-1:0] stack_mem [STACK_DEPTH];
   logic [WordWidth-1:0] var_mem [StoreSize];
   logic [StoreSize-1:0] valid_ff;
   logic [WordWidth-1:0] a_ff, b_ff, v_ff, res;
   logic [WordWidth-1:0] quo, rem;
   logic                 div_busy;
   logic [StackAw-1:0]   top_addr, sec_addr, wr_addr;
   logic                 wr_en;
   logic [WordWidth-1:0] wr_data;
   logic [StoreAw-1:0]   vaddr;
   logic                 div_start, mul_start, mul_busy;
   logic [WordWidth-1:0] mul_acc_ff, mul_acc_in;
   logic [1:0]           mul_cnt_ff, mul_cnt_in;
   logic [HalfWidth-1:0] mul_x, mul_y;
   logic [WordWidth-1:0] mul_prod, mul_add;

   assign vaddr    = var_idx[StoreAw-1:0];
   assign top_addr = StackAw'(count - 1'b1);
   assign sec_addr = StackAw'(count - CountWidth'(2));

   always_comb begin
      wr_en = 1'b0; wr_addr = top_addr; wr_data = res;
      unique case (cmd.act)
         ACT_PUSH:     begin wr_en = 1'b1; wr_addr = StackAw'(count); wr_data = push_value; end
         ACT_LOAD:     begin wr_en = 1'b1; wr_addr = StackAw'(count); wr_data = v_ff; end
         ACT_ALU:      begin wr_en = 1'b1; wr_addr = (cmd.op == OP_NEG) ? top_addr : sec_addr; end
         ACT_DIV_DONE: begin wr_en = 1'b1; wr_addr = sec_addr; end
         default:      wr_en = 1'b0;
      endcase
   end

   always_comb begin
      case (cmd.op)
         OP_ADD:  res = a_ff + b_ff;
         OP_SUB:  res = a_ff - b_ff;
         OP_MUL:  res = mul_acc_ff;
         OP_DIV:  res = quo;
         OP_MOD:  res = rem;
         OP_OR:   res = a_ff | b_ff;
         OP_AND:  res = a_ff & b_ff;
         OP_NEG:  res = -a_ff;
         default: res = a_ff ^ b_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.act == ACT_READ) begin
         a_ff <= stack_mem[top_addr];
         b_ff <= stack_mem[sec_addr];
         v_ff <= var_mem[vaddr];
      end
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      if (cmd.act == ACT_STORE) var_mem[vaddr] <= a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.act == ACT_STORE) begin
         valid_ff[vaddr] <= 1'b1;
      end
   end

   // multi-cycle start serves both the divider and the multiplier
   assign div_start = (cmd.act == ACT_DIV_START) && (cmd.op != OP_MUL);
   assign mul_start = (cmd.act == ACT_DIV_START) && (cmd.op == OP_MUL);

   sme_divider u_div (
      .clock, .reset, .start(div_start), .dividend(a_ff),
      .divisor(b_ff), .busy(div_busy), .quotient(quo), .remainder(rem)
   );

   // low word of the product from three half-width partial products
   assign mul_busy = (mul_cnt_ff != 2'd0);
   assign mul_x    = (mul_cnt_ff == 2'd1) ? a_ff[WordWidth-1:HalfWidth] : a_ff[HalfWidth-1:0];
   assign mul_y    = (mul_cnt_ff == 2'd2) ? b_ff[WordWidth-1:HalfWidth] : b_ff[HalfWidth-1:0];
   assign mul_prod = WordWidth'(mul_x) * WordWidth'(mul_y);
   assign mul_add  = (mul_cnt_ff == 2'd3) ? mul_prod
                                          : {mul_prod[HalfWidth-1:0], {HalfWidth{1'b0}}};

   always_comb begin
      mul_acc_in = mul_acc_ff; mul_cnt_in = mul_cnt_ff;
      if (mul_start) begin
         mul_acc_in = '0; mul_cnt_in = 2'd3;
      end else if (mul_busy) begin
         mul_acc_in = mul_acc_ff + mul_add; mul_cnt_in = mul_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_cnt_ff <= '0;
      end else begin
         mul_cnt_ff <= mul_cnt_in;
      end
      mul_acc_ff <= mul_acc_in;
   end

   assign sts.div_busy  = div_busy | mul_busy;
   assign sts.b_zero    = (b_ff == '0);
   assign sts.var_valid = valid_ff[vaddr];
   assign top_value     = a_ff;
endmodule
`default_nettype wire

@@ rtl/sme_controller.sv @@
// Controller: decodes each instruction, checks stack bounds, sequences the datapath.
// Depends on sme_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sme_controller import sme_pkg::*; #(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned NUM_CONTEXTS = 16,
   parameter int unsigned VARS_PER_CONTEXT = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [OpWidth-1:0]   in_op,
   input  wire logic [WordWidth-1:0] in_imm,
   input  wire logic [SelWidth-1:0]  in_ctx,
   input  wire logic [SelWidth-1:0]  in_var,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [StatWidth-1:0]      out_status,
   output logic                      out_print,
   output logic [WordWidth-1:0]      out_value,
   output cmd_type                   cmd,
   output logic [WordWidth-1:0]      push_value,
   output logic [$clog2(STACK_DEPTH+1)-1:0] count,
   output logic [$clog2(NUM_CONTEXTS*VARS_PER_CONTEXT)-1:0] var_idx,
   input  sts_type                   sts,
   input  wire logic [WordWidth-1:0] top_value
);
   localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);
   localparam int unsigned IdxWidth = $clog2(NUM_CONTEXTS * VARS_PER_CONTEXT);
   localparam int unsigned CtxAw = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int unsigned VarAw = (VARS_PER_CONTEXT > 1) ? $clog2(VARS_PER_CONTEXT) : 1;

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV_WAIT, S_DIV_END, S_RESP} state_type;

   state_type              state_ff;
   logic [OpWidth-1:0]     op_ff;
   logic [WordWidth-1:0]   imm_ff;
   logic [SelWidth-1:0]    ctx_ff, var_ff, cur_ctx_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [StatWidth-1:0]   status_ff;
   logic                   print_ff;
   logic [WordWidth-1:0]   value_ff;
   logic                   div_started_ff;
   logic [OpWidth-1:0]     op_use;
   logic [SelWidth-1:0]    ctx_sel_use, var_use;
   logic [SelWidth-1:0]    ctx_use;
   logic [CtxAw-1:0]       ctx_red;
   logic [VarAw-1:0]       var_red;
   logic                   full, has1, has2;

   // in idle the store index follows the incoming item so the read at accept sees it
   assign op_use      = (state_ff == S_IDLE) ? in_op : op_ff;
   assign ctx_sel_use = (state_ff == S_IDLE) ? in_ctx : ctx_ff;
   assign var_use     = (state_ff == S_IDLE) ? in_var : var_ff;

   assign full = (count_ff == CountWidth'(STACK_DEPTH));
   assign has1 = (count_ff != '0);
   assign has2 = (count_ff > CountWidth'(1));
   assign ctx_use = (op_use == OP_LOAD_LOC || op_use == OP_STORE_LOC) ? cur_ctx_ff : ctx_sel_use;
   assign ctx_red = CtxAw'(32'(ctx_use) % NUM_CONTEXTS);
   assign var_red = VarAw'(32'(var_use) % VARS_PER_CONTEXT);
   assign var_idx = IdxWidth'(32'(ctx_red) * VARS_PER_CONTEXT + 32'(var_red));
   assign count = count_ff;

   always_comb begin
      cmd.op = op_ff; cmd.act = ACT_NONE;
      push_value = imm_ff;
      case (op_ff)
         OP_PUSH_ZERO: push_value = '0;
         OP_PUSH_ONE:  push_value = WordWidth'(1);
         OP_PUSH_M1:   push_value = '1;
         default:      push_value = imm_ff;
      endcase
      unique case (state_ff)
         S_IDLE: if (in_valid) cmd.act = ACT_READ;
         S_EXEC: begin
            case (op_ff) inside
               [OP_PUSH_IMM:OP_PUSH_M1]: if (!full) cmd.act = ACT_PUSH;
               OP_ADD, OP_SUB, OP_OR, OP_AND, OP_XOR:
                  if (has2) cmd.act = ACT_ALU;
               OP_MUL: if (has2) cmd.act = ACT_DIV_START;
               OP_DIV, OP_MOD: if (has2 && !sts.b_zero) cmd.act = ACT_DIV_START;
               OP_NEG: if (has1) cmd.act = ACT_ALU;
               OP_LOAD_LOC, OP_LOAD_CTX:
                  if (!full && sts.var_valid) cmd.act = ACT_LOAD;
               OP_STORE_LOC, OP_STORE_CTX: if (has1) cmd.act = ACT_STORE;
               default: cmd.act = ACT_NONE;
            endcase
         end
         S_DIV_END: cmd.act = ACT_DIV_DONE;
         default: cmd.act = ACT_NONE;
      endcase
   end

   // Operands and the variable are read at the accepting edge; EXEC uses them.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; cur_ctx_ff <= '0;
         div_started_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               status_ff <= ST_OK; print_ff <= 1'b0; value_ff <= '0;
               state_ff <= S_RESP;
               case (op_ff) inside
                  [OP_PUSH_IMM:OP_PUSH_M1]:
                     if (full) status_ff <= ST_OVER; else count_ff <= count_ff + 1'b1;
                  OP_ADD, OP_SUB, OP_OR, OP_AND, OP_XOR:
                     if (!has2) status_ff <= ST_UNDER; else count_ff <= count_ff - 1'b1;
                  OP_MUL:
                     if (!has2) status_ff <= ST_UNDER;
                     else state_ff <= S_DIV_WAIT;
                  OP_DIV, OP_MOD:
                     if (!has2) status_ff <= ST_UNDER;
                     else if (sts.b_zero) status_ff <= ST_DIVZERO;
                     else state_ff <= S_DIV_WAIT;
                  OP_NEG: if (!has1) status_ff <= ST_UNDER;
                  OP_PRINT:
                     if (!has1) status_ff <= ST_UNDER;
                     else begin
                        count_ff <= count_ff - 1'b1; print_ff <= 1'b1; value_ff <= top_value;
                     end
                  OP_POP:
                     if (!has1) status_ff <= ST_UNDER; else count_ff <= count_ff - 1'b1;
                  OP_LOAD_LOC, OP_LOAD_CTX:
                     if (full) status_ff <= ST_OVER;
                     else if (!sts.var_valid) status_ff <= ST_UNWRITTEN;
                     else count_ff <= count_ff + 1'b1;
                  OP_STORE_LOC, OP_STORE_CTX:
                     if (!has1) status_ff <= ST_UNDER; else count_ff <= count_ff - 1'b1;
                  OP_SET_CTX: cur_ctx_ff <= SelWidth'(ctx_red);
                  default: status_ff <= ST_BADOP;
               endcase
            end
            S_DIV_WAIT: begin
               div_started_ff <= 1'b1;
               if (div_started_ff && !sts.div_busy) begin
                  state_ff <= S_DIV_END; div_started_ff <= 1'b0;
               end
            end
            S_DIV_END: begin
               count_ff <= count_ff - 1'b1; state_ff <= S_RESP;
            end
            S_RESP: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
      if (state_ff == S_IDLE && in_valid) begin
         op_ff <= in_op; imm_ff <= in_imm; ctx_ff <= in_ctx; var_ff <= in_var;
      end
   end

   assign in_ready   = (state_ff == S_IDLE);
   assign out_valid  = (state_ff == S_RESP);
   assign out_status = status_ff;
   assign out_print  = print_ff;
   assign out_value  = value_ff;
endmodule
`default_nettype wire

@@ rtl/stack_machine_integer_executor_top.sv @@
// Integer stack-machine executor: one instruction per item, one response per item.
// An item passes through accept with operand read, execute and response; mul adds
// a wait for three half-width partial products, div and mod a wait for the bit-serial
// divider. A held response stalls the next accept.
// Depends on sme_pkg, sme_controller, sme_datapath, sme_divider.
`timescale 1ns / 1ps
`default_nettype none
module stack_machine_integer_executor_top import sme_pkg::*; #(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned NUM_CONTEXTS = 16,
   parameter int unsigned VARS_PER_CONTEXT = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OpWidth-1:0]   req_op,
   input  wire logic [WordWidth-1:0] req_immediate,
   input  wire logic [SelWidth-1:0]  req_context_sel,
   input  wire logic [SelWidth-1:0]  req_variable_sel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [StatWidth-1:0]      rsp_status,
   output logic                      rsp_print_valid,
   output logic [WordWidth-1:0]      rsp_print_value
);
   cmd_type cmd;
   sts_type sts;
   logic [WordWidth-1:0] push_value, top_value;
   logic [$clog2(STACK_DEPTH+1)-1:0] count;
   logic [$clog2(NUM_CONTEXTS*VARS_PER_CONTEXT)-1:0] var_idx;

   sme_controller #(.STACK_DEPTH(STACK_DEPTH), .NUM_CONTEXTS(NUM_CONTEXTS),
      .VARS_PER_CONTEXT(VARS_PER_CONTEXT)) u_ctrl (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_op(req_op),
      .in_imm(req_immediate), .in_ctx(req_context_sel), .in_var(req_variable_sel),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_status(rsp_status),
      .out_print(rsp_print_valid), .out_value(rsp_print_value), .cmd, .push_value,
      .count, .var_idx, .sts, .top_value
   );

   sme_datapath #(.STACK_DEPTH(STACK_DEPTH), .NUM_CONTEXTS(NUM_CONTEXTS),
      .VARS_PER_CONTEXT(VARS_PER_CONTEXT)) u_dp (
      .clock, .reset, .cmd, .push_value, .count, .var_idx, .sts, .top_value
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while response pending");
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> rsp_status == ST_OK) else $error("print with error");
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for stack_machine_integer_executor_top: directed, stack-limit
// and random instruction streams, with an in-bench predictor and randomized idling.
// Depends on sme_pkg, sme_if and the executor RTL.
`timescale 1ns / 1ps
module testbench;
   import sme_pkg::*;

   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [WordWidth-1:0] immediate;
      logic [SelWidth-1:0]  context_sel;
      logic [SelWidth-1:0]  variable_sel;
   } instr_t;

   typedef struct packed {
      logic [StatWidth-1:0] status;
      logic                 print_valid;
      logic [WordWidth-1:0] print_value;
   } outcome_t;

   localparam int Depth = 64;
   localparam logic [WordWidth-1:0] MinWord = {1'b1, 63'd0};
   localparam logic [WordWidth-1:0] MaxWord = {1'b0, {63{1'b1}}};
   localparam logic [WordWidth-1:0] AllOnes = '1;
   localparam logic [OpWidth-1:0] OpBadLow = 5'd20;
   localparam logic [OpWidth-1:0] OpBadHigh = 5'd31;

   logic clock = 0;
   logic reset = 1;
   always #10 clock = ~clock;

   sme_if #(.payload_type(instr_t)) req_ch ();
   sme_if #(.payload_type(outcome_t)) rsp_ch ();

   stack_machine_integer_executor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_op(req_ch.payload.op), .req_immediate(req_ch.payload.immediate),
      .req_context_sel(req_ch.payload.context_sel),
      .req_variable_sel(req_ch.payload.variable_sel),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_status(rsp_ch.payload.status), .rsp_print_valid(rsp_ch.payload.print_valid),
      .rsp_print_value(rsp_ch.payload.print_value)
   );

   // predictor state
   logic [WordWidth-1:0] stack_mem [Depth];
   int                   depth_used;
   logic [WordWidth-1:0] var_mem [256];
   logic                 var_written [256];
   logic [SelWidth-1:0]  cur_ctx;

   outcome_t pending_outcomes [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  outcomes_seen = 0;
   bit  quiet = 0;

   function automatic logic [WordWidth-1:0] mag(logic [WordWidth-1:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [StatWidth-1:0] push_word(logic [WordWidth-1:0] v);
      if (depth_used >= Depth) return ST_OVER;
      stack_mem[depth_used] = v;
      depth_used++;
      return ST_OK;
   endfunction

   function automatic logic [StatWidth-1:0] load_var(int idx);
      if (depth_used >= Depth) return ST_OVER;
      if (!var_written[idx]) return ST_UNWRITTEN;
      return push_word(var_mem[idx]);
   endfunction

   function automatic logic [StatWidth-1:0] store_var(int idx);
      if (depth_used < 1) return ST_UNDER;
      depth_used--;
      var_mem[idx] = stack_mem[depth_used];
      var_written[idx] = 1;
      return ST_OK;
   endfunction

   function automatic outcome_t execute(instr_t it);
      outcome_t o;
      logic [WordWidth-1:0] a, b, r, q;
      o = '0;
      case (it.op)
         OP_PUSH_IMM:  o.status = push_word(it.immediate);
         OP_PUSH_ZERO: o.status = push_word('0);
         OP_PUSH_ONE:  o.status = push_word(64'd1);
         OP_PUSH_M1:   o.status = push_word(AllOnes);
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR: begin
            if (depth_used < 2) begin
               o.status = ST_UNDER;
            end else begin
               a = stack_mem[depth_used-1];
               b = stack_mem[depth_used-2];
               if ((it.op == OP_DIV || it.op == OP_MOD) && b == 0) begin
                  o.status = ST_DIVZERO;
               end else begin
                  case (it.op)
                     OP_ADD: r = a + b;
                     OP_SUB: r = a - b;
                     OP_MUL: r = a * b;
                     OP_DIV: begin
                        q = mag(a) / mag(b);
                        r = (a[63] ^ b[63]) ? -q : q;
                     end
                     OP_MOD: begin
                        q = mag(a) % mag(b);
                        r = a[63] ? -q : q;
                     end
                     OP_OR:  r = a | b;
                     OP_AND: r = a & b;
                     default: r = a ^ b;
                  endcase
                  depth_used--;
                  stack_mem[depth_used-1] = r;
               end
            end
         end
         OP_NEG: begin
            if (depth_used < 1) o.status = ST_UNDER;
            else stack_mem[depth_used-1] = -stack_mem[depth_used-1];
         end
         OP_PRINT: begin
            if (depth_used < 1) begin
               o.status = ST_UNDER;
            end else begin
               depth_used--;
               o.print_valid = 1;
               o.print_value = stack_mem[depth_used];
            end
         end
         OP_POP: begin
            if (depth_used < 1) o.status = ST_UNDER;
            else depth_used--;
         end
         OP_LOAD_LOC:  o.status = load_var({cur_ctx, it.variable_sel});
         OP_STORE_LOC: o.status = store_var({cur_ctx, it.variable_sel});
         OP_LOAD_CTX:  o.status = load_var({it.context_sel, it.variable_sel});
         OP_STORE_CTX: o.status = store_var({it.context_sel, it.variable_sel});
         OP_SET_CTX:   cur_ctx = it.context_sel;
         default:      o.status = ST_BADOP;
      endcase
      return o;
   endfunction

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      depth_used = 0;
      cur_ctx = 0;
      foreach (var_written[i]) var_written[i] = 0;
   end

   always @(negedge clock) rsp_ch.ready <= quiet || ($urandom_range(99) >= 26);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", rsp_ch.payload);
         end else begin
            outcome_t e;
            e = pending_outcomes.pop_front();
            if (rsp_ch.payload.status !== e.status
                || rsp_ch.payload.print_valid !== e.print_valid
                || rsp_ch.payload.print_value !== e.print_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st=%0d pv=%0d val=%h, got st=%0d pv=%0d val=%h",
                           e.status, e.print_valid, e.print_value, rsp_ch.payload.status,
                           rsp_ch.payload.print_valid, rsp_ch.payload.print_value);
            end
         end
      end
   end

   task automatic send(logic [OpWidth-1:0] op, logic [WordWidth-1:0] imm = '0,
                       logic [SelWidth-1:0] ctx = '0, logic [SelWidth-1:0] vsel = '0);
      instr_t it;
      int gap;
      it.op = op;
      it.immediate = imm;
      it.context_sel = ctx;
      it.variable_sel = vsel;
      if (!quiet && $urandom_range(99) < 26) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.payload <= it;
      req_ch.valid <= 1;
      do @(posedge clock); while (!req_ch.ready);
      pending_outcomes.push_back(execute(it));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   function automatic logic [WordWidth-1:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return AllOnes;
         2: return MinWord;
         3: return MaxWord;
         4: return 64'($signed($urandom_range(20)) - 10);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_directed();
      send(OP_POP);
      send(OP_PRINT);
      send(OP_NEG);
      send(OP_STORE_LOC, '0, '0, 4'd3);
      send(OP_LOAD_LOC, '0, '0, 4'd0);
      send(OP_PUSH_IMM, MaxWord);
      send(OP_ADD);
      send(OP_PUSH_IMM, MinWord);
      send(OP_ADD);
      send(OP_PUSH_ZERO);
      send(OP_PUSH_ONE);
      send(OP_DIV);
      send(OP_MOD);
      send(OP_POP);
      send(OP_POP);
      send(OP_PUSH_M1);
      send(OP_PUSH_IMM, MinWord);
      send(OP_DIV);
      send(OP_PUSH_M1);
      send(OP_PUSH_IMM, MinWord);
      send(OP_MOD);
      send(OP_STORE_CTX, '0, 4'd15, 4'd15);
      send(OP_SET_CTX, '0, 4'd15);
      send(OP_LOAD_LOC, '0, '0, 4'd15);
      send(OP_LOAD_CTX, '0, 4'd15, 4'd15);
      send(OP_SUB);
      send(OP_PUSH_IMM, 64'h0123_4567_89ab_cdef);
      send(OP_MUL);
      send(OP_PUSH_IMM, AllOnes);
      send(OP_OR);
      send(OP_PUSH_IMM, 64'hf0f0);
      send(OP_AND);
      send(OP_PUSH_IMM, MaxWord);
      send(OP_XOR);
      send(OP_PRINT);
      send(OpBadLow);
      send(OpBadHigh);
      send(OP_SET_CTX, '0, 4'd0);
   endtask

   task automatic test_stack_limits();
      while (depth_used < Depth) send(OP_PUSH_IMM, rand_word());
      send(OP_PUSH_ONE);
      send(OP_LOAD_CTX, '0, 4'd7, 4'd9);
      send(OP_LOAD_CTX, '0, 4'd15, 4'd15);
      while (depth_used > 0) send(OP_PRINT);
   endtask

   task automatic test_random(int count);
      int r;
      logic [OpWidth-1:0] op;
      for (int n = 0; n < count; n++) begin
         if (n == count / 3) quiet = 1;
         if (n == count / 2) quiet = 0;
         r = $urandom_range(99);
         if (r < 3) op = 5'($urandom_range(OpBadLow, OpBadHigh));
         else if (depth_used < 2 && r < 60) op = 5'($urandom_range(OP_PUSH_IMM, OP_PUSH_M1));
         else if (depth_used > 48 && r < 70) op = 5'($urandom_range(OP_ADD, OP_POP));
         else if (r < 30) op = OP_PUSH_IMM;
         else if (r < 40) op = 5'($urandom_range(OP_PUSH_ZERO, OP_PUSH_M1));
         else if (r < 70) op = 5'($urandom_range(OP_ADD, OP_POP));
         else op = 5'($urandom_range(OP_LOAD_LOC, OP_SET_CTX));
         send(op, rand_word(), 4'($urandom), 4'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_directed();
      test_stack_limits();
      drain();
      test_random(490);
      drain();
      test_random(490);
      drain();
      $display("Ran %0d instructions and checked %0d results, %0d mismatches.",
               items_sent, outcomes_seen, mismatches);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timed out with %0d results outstanding.", pending_outcomes.size());
      $display("Some tests failed");
      $finish;
   end
endmodule
